### hw/rtl/bsp_pkg.sv
// ----------------------------------------------------------------------------
// bsp_pkg
// Types and constants shared by the box surface projection pipeline.
// ----------------------------------------------------------------------------
package bsp_pkg;

  localparam int MAG_W  = 33;
  localparam int EXT_W  = 34;
  localparam int LO_W   = 17;
  localparam int HI_W   = EXT_W - LO_W;
  localparam int PART_W = MAG_W + LO_W;
  localparam int PROD_W = MAG_W + EXT_W;
  localparam int QUO_W  = 34;
  localparam int REM_W  = 34;
  localparam int NSTAGE = 4 + QUO_W + 1;

  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_CENTER_Z = 3'd2;
  localparam logic [2:0] REG_EXTENT_X = 3'd3;
  localparam logic [2:0] REG_EXTENT_Y = 3'd4;
  localparam logic [2:0] REG_EXTENT_Z = 3'd5;
  localparam logic [2:0] REG_SHELL_XY = 3'd6;
  localparam logic [2:0] REG_SHELL_Z  = 3'd7;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               outer_box;
  } in_t;

  typedef struct packed {
    logic signed [31:0] surface_x;
    logic signed [31:0] surface_y;
    logic signed [31:0] surface_z;
    logic               degenerate;
    logic               clipped;
  } out_t;

  typedef logic [MAG_W-1:0]  mag_t;
  typedef logic [EXT_W-1:0]  ext_t;
  typedef logic [PROD_W-1:0] prod_t;

endpackage

### hw/rtl/bsp_prep.sv
// ----------------------------------------------------------------------------
// bsp_prep
// One axis: offset from center, its magnitude and sign, and the box size.
// ----------------------------------------------------------------------------
module bsp_prep import bsp_pkg::*; (
  input  logic               clk,
  input  logic               adv,
  input  logic signed [31:0] point,
  input  logic signed [31:0] center,
  input  logic [30:0]        extent,
  input  logic [31:0]        shell,
  input  logic               outer,
  output logic               neg_r,
  output mag_t               mag_r,
  output ext_t               ext_r
);

  logic signed [32:0] diff;
  logic               neg_nxt;
  mag_t               mag_nxt;
  ext_t               ext_nxt;

  always_comb begin
    diff    = {point[31], point} - {center[31], center};
    neg_nxt = diff[32];
    mag_nxt = neg_nxt ? MAG_W'(-diff) : MAG_W'(diff);
    ext_nxt = {3'b000, extent} + (outer ? {1'b0, shell, 1'b0} : '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg_r <= neg_nxt;
      mag_r <= mag_nxt;
      ext_r <= ext_nxt;
    end
  end

endmodule

### hw/rtl/bsp_pick.sv
// ----------------------------------------------------------------------------
// bsp_pick
// Cross products of the lanes, dominant axis choice, divider operands.
// ----------------------------------------------------------------------------
module bsp_pick import bsp_pkg::*; (
  input  logic  clk,
  input  logic  adv,
  input  logic  neg   [3],
  input  mag_t  mag   [3],
  input  ext_t  ext   [3],
  output prod_t num_r [3],
  output logic [REM_W-1:0] div_r [3],
  output logic  neg_o_r [3],
  output logic  degen_r
);

  logic [PART_W-1:0] pl_r [3][3];
  logic [PART_W-1:0] ph_r [3][3];
  prod_t             prod_r [3][3];
  mag_t              mag1_r [3];
  mag_t              mag2_r [3];
  ext_t              ext1_r [3];
  ext_t              ext2_r [3];
  logic              neg1_r [3];
  logic              neg2_r [3];
  logic [1:0]        m;
  logic              degen_nxt;
  prod_t             num_nxt [3];
  mag_t              mm;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pl_r[i][j]   <= PART_W'(mag[i] * ext[j][LO_W-1:0]);
          ph_r[i][j]   <= PART_W'(mag[i] * ext[j][EXT_W-1:LO_W]);
          prod_r[i][j] <= PROD_W'(pl_r[i][j]) + (PROD_W'(ph_r[i][j]) << LO_W);
        end
        mag1_r[i] <= mag[i];
        ext1_r[i] <= ext[i];
        neg1_r[i] <= neg[i];
        mag2_r[i] <= mag1_r[i];
        ext2_r[i] <= ext1_r[i];
        neg2_r[i] <= neg1_r[i];
      end
    end
  end

  always_comb begin
    m = 2'd0;
    if (prod_r[1][0] > prod_r[0][1]) begin
      m = 2'd1;
    end
    if ((m == 2'd0 && prod_r[2][0] > prod_r[0][2]) ||
        (m == 2'd1 && prod_r[2][1] > prod_r[1][2])) begin
      m = 2'd2;
    end
    degen_nxt = (ext2_r[0] == '0) || (ext2_r[1] == '0) || (ext2_r[2] == '0) ||
                ((mag2_r[0] == '0) && (mag2_r[1] == '0) && (mag2_r[2] == '0));
    for (int a = 0; a < 3; a++) begin
      case (m)
        2'd1:    num_nxt[a] = prod_r[a][1];
        2'd2:    num_nxt[a] = prod_r[a][2];
        default: num_nxt[a] = prod_r[a][0];
      endcase
    end
    case (m)
      2'd1:    mm = mag2_r[1];
      2'd2:    mm = mag2_r[2];
      default: mm = mag2_r[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        num_r[a]   <= num_nxt[a] + PROD_W'(mm);
        div_r[a]   <= {mm, 1'b0};
        neg_o_r[a] <= neg2_r[a];
      end
      degen_r <= degen_nxt;
    end
  end

endmodule

### hw/rtl/bsp_div_lane.sv
// ----------------------------------------------------------------------------
// bsp_div_lane
// One axis: pipelined restoring divider, one quotient bit per stage, then
// the offset is added to the center and saturated.
// ----------------------------------------------------------------------------
module bsp_div_lane import bsp_pkg::*; (
  input  logic               clk,
  input  logic               adv,
  input  prod_t              num,
  input  logic [REM_W-1:0]   div,
  input  logic               neg,
  input  logic               degen,
  input  logic signed [31:0] center,
  output logic signed [31:0] surf_r,
  output logic               clip_r,
  output logic               degen_o_r
);

  logic [REM_W-1:0] rem_r   [QUO_W];
  logic [QUO_W-1:0] low_r   [QUO_W];
  logic [REM_W-1:0] div_r   [QUO_W];
  logic             neg_r   [QUO_W];
  logic             degen_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [REM_W-1:0] rem_in;
    logic [QUO_W-1:0] low_in;
    logic [REM_W-1:0] div_in;
    logic             neg_in;
    logic             degen_in;
    logic [REM_W:0]   t;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in   = REM_W'(num[PROD_W-1:QUO_W]);
      assign low_in   = num[QUO_W-1:0];
      assign div_in   = div;
      assign neg_in   = neg;
      assign degen_in = degen;
    end else begin : g_next
      assign rem_in   = rem_r[k-1];
      assign low_in   = low_r[k-1];
      assign div_in   = div_r[k-1];
      assign neg_in   = neg_r[k-1];
      assign degen_in = degen_r[k-1];
    end

    assign t  = {rem_in, low_in[QUO_W-1]};
    assign ge = t >= {1'b0, div_in};

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]   <= ge ? REM_W'(t - {1'b0, div_in}) : REM_W'(t);
        low_r[k]   <= {low_in[QUO_W-2:0], ge};
        div_r[k]   <= div_in;
        neg_r[k]   <= neg_in;
        degen_r[k] <= degen_in;
      end
    end
  end

  logic signed [35:0] off;
  logic signed [35:0] sum;
  logic signed [31:0] surf_nxt;
  logic               clip_nxt;

  always_comb begin
    off = $signed({2'b00, low_r[QUO_W-1]});
    if (neg_r[QUO_W-1]) begin
      off = -off;
    end
    sum      = 36'(center) + off;
    surf_nxt = sum[31:0];
    clip_nxt = 1'b0;
    if (degen_r[QUO_W-1]) begin
      surf_nxt = center;
    end else if (sum > 36'sh0_7FFF_FFFF) begin
      surf_nxt = 32'sh7FFF_FFFF;
      clip_nxt = 1'b1;
    end else if (sum < -36'sh0_8000_0000) begin
      surf_nxt = 32'sh8000_0000;
      clip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      surf_r    <= surf_nxt;
      clip_r    <= clip_nxt;
      degen_o_r <= degen_r[QUO_W-1];
    end
  end

endmodule

### hw/rtl/box_surface_projection.sv
// ----------------------------------------------------------------------------
// box_surface_projection
// Projects a point along the ray from the box center onto the box surface.
// ----------------------------------------------------------------------------
// One request enters per cycle while the output is not stalled. Each of the
// three axis lanes holds a 34-stage restoring divider, behind four stages of
// offset, cross products and axis choice. The whole pipeline holds while a
// result waits at the output.
module box_surface_projection import bsp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  logic signed [31:0] center_r [3];
  logic [30:0]        extent_r [3];
  logic [31:0]        shell_r  [3];
  logic [2:0]         idx;
  logic               wr;
  logic               adv;
  logic [NSTAGE-1:0]  v_r;

  assign cfg_pready = 1'b1;
  assign idx = cfg_paddr[5:3];
  assign wr  = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        center_r[a] <= '0;
        extent_r[a] <= 31'd65536;
        shell_r[a]  <= '0;
      end
    end else if (wr) begin
      case (idx)
        REG_CENTER_X: center_r[0] <= cfg_pwdata[31:0];
        REG_CENTER_Y: center_r[1] <= cfg_pwdata[31:0];
        REG_CENTER_Z: center_r[2] <= cfg_pwdata[31:0];
        REG_EXTENT_X: extent_r[0] <= cfg_pwdata[30:0];
        REG_EXTENT_Y: extent_r[1] <= cfg_pwdata[30:0];
        REG_EXTENT_Z: extent_r[2] <= cfg_pwdata[30:0];
        REG_SHELL_XY: begin
          shell_r[0] <= cfg_pwdata[31:0];
          shell_r[1] <= cfg_pwdata[63:32];
        end
        REG_SHELL_Z:  shell_r[2] <= cfg_pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CENTER_X: cfg_prdata = {32'd0, center_r[0]};
      REG_CENTER_Y: cfg_prdata = {32'd0, center_r[1]};
      REG_CENTER_Z: cfg_prdata = {32'd0, center_r[2]};
      REG_EXTENT_X: cfg_prdata = {33'd0, extent_r[0]};
      REG_EXTENT_Y: cfg_prdata = {33'd0, extent_r[1]};
      REG_EXTENT_Z: cfg_prdata = {33'd0, extent_r[2]};
      REG_SHELL_XY: cfg_prdata = {shell_r[1], shell_r[0]};
      REG_SHELL_Z:  cfg_prdata = {32'd0, shell_r[2]};
      default:      cfg_prdata = '0;
    endcase
  end

  assign adv       = !v_r[NSTAGE-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = v_r[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NSTAGE-2:0], in_valid};
    end
  end

  logic signed [31:0] point [3];
  logic  neg [3];
  mag_t  mag [3];
  ext_t  ext [3];
  prod_t num [3];
  logic [REM_W-1:0] div [3];
  logic  neg_p [3];
  logic  degen_p;
  logic signed [31:0] surf [3];
  logic  clip [3];
  logic  degen_l [3];

  assign point[0] = in_data.point_x;
  assign point[1] = in_data.point_y;
  assign point[2] = in_data.point_z;

  for (genvar a = 0; a < 3; a++) begin : g_prep
    bsp_prep u_prep (
      .clk    (clk),
      .adv    (adv),
      .point  (point[a]),
      .center (center_r[a]),
      .extent (extent_r[a]),
      .shell  (shell_r[a]),
      .outer  (in_data.outer_box),
      .neg_r  (neg[a]),
      .mag_r  (mag[a]),
      .ext_r  (ext[a])
    );
  end

  bsp_pick u_pick (
    .clk     (clk),
    .adv     (adv),
    .neg     (neg),
    .mag     (mag),
    .ext     (ext),
    .num_r   (num),
    .div_r   (div),
    .neg_o_r (neg_p),
    .degen_r (degen_p)
  );

  for (genvar a = 0; a < 3; a++) begin : g_lane
    bsp_div_lane u_lane (
      .clk       (clk),
      .adv       (adv),
      .num       (num[a]),
      .div       (div[a]),
      .neg       (neg_p[a]),
      .degen     (degen_p),
      .center    (center_r[a]),
      .surf_r    (surf[a]),
      .clip_r    (clip[a]),
      .degen_o_r (degen_l[a])
    );
  end

  always_comb begin
    out_data.surface_x  = surf[0];
    out_data.surface_y  = surf[1];
    out_data.surface_z  = surf[2];
    out_data.degenerate = degen_l[0];
    out_data.clipped    = clip[0] | clip[1] | clip[2];
  end

`ifndef SYNTHESIS
  a_degen_noclip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |-> !out_data.clipped)
    else $error("degenerate result marked clipped");

  a_degen_center: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.surface_x == center_r[0] && out_data.surface_y == center_r[1] &&
      out_data.surface_z == center_r[2])
    else $error("degenerate result differs from center");

  a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> degen_l[0] == degen_l[1] && degen_l[1] == degen_l[2])
    else $error("lanes disagree on degenerate");
`endif

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams points through the box surface projection and checks every result
// against an exact integer projection computed here, over several box setups.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import bsp_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [5:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  box_surface_projection uut (.*);

  always #10 clk = ~clk;

  logic signed [33:0] ctr [3];
  logic [33:0] ext_inner [3];
  logic [33:0] shell_w [3];
  out_t surface_queue [$];
  int errors = 0;
  int results_seen = 0;
  int requests_sent = 0;
  bit no_idle = 1'b0;

  function automatic out_t project_point(in_t p);
    out_t r;
    logic signed [34:0] d [3];
    logic [33:0] mag [3];
    logic [34:0] e [3];
    logic [127:0] lhs, rhs, num, q;
    logic signed [35:0] s;
    bit degen;
    int m;
    degen = 1'b0;
    m = 0;
    r = '0;
    d[0] = p.point_x - ctr[0];
    d[1] = p.point_y - ctr[1];
    d[2] = p.point_z - ctr[2];
    for (int a = 0; a < 3; a++) begin
      mag[a] = d[a] < 0 ? -d[a] : d[a];
      e[a] = ext_inner[a] + (p.outer_box ? 2 * shell_w[a] : 0);
      if (e[a] == 0) degen = 1'b1;
    end
    if (mag[0] == 0 && mag[1] == 0 && mag[2] == 0) degen = 1'b1;
    if (!degen) begin
      for (int a = 1; a < 3; a++) begin
        lhs = 128'(mag[a]) * 128'(e[m]);
        rhs = 128'(mag[m]) * 128'(e[a]);
        if (lhs > rhs) m = a;
      end
    end
    for (int a = 0; a < 3; a++) begin
      s = ctr[a];
      if (!degen) begin
        num = 128'(mag[a]) * 128'(e[m]) + 128'(mag[m]);
        q = num / (128'(mag[m]) * 2);
        s = d[a] < 0 ? ctr[a] - $signed({1'b0, q[34:0]}) : ctr[a] + $signed({1'b0, q[34:0]});
        if (s > 36'sd2147483647) begin
          s = 36'sd2147483647;
          r.clipped = 1'b1;
        end
        if (s < -36'sd2147483648) begin
          s = -36'sd2147483648;
          r.clipped = 1'b1;
        end
      end
      case (a)
        0: r.surface_x = s[31:0];
        1: r.surface_y = s[31:0];
        default: r.surface_z = s[31:0];
      endcase
    end
    r.degenerate = degen;
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 3'b000};
    cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_CENTER_X: ctr[0] = $signed(val[31:0]);
      REG_CENTER_Y: ctr[1] = $signed(val[31:0]);
      REG_CENTER_Z: ctr[2] = $signed(val[31:0]);
      REG_EXTENT_X: ext_inner[0] = val[30:0];
      REG_EXTENT_Y: ext_inner[1] = val[30:0];
      REG_EXTENT_Z: ext_inner[2] = val[30:0];
      REG_SHELL_XY: begin
        shell_w[0] = val[31:0];
        shell_w[1] = val[63:32];
      end
      default: shell_w[2] = val[31:0];
    endcase
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic set_box(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                         logic [30:0] ex, logic [30:0] ey, logic [30:0] ez,
                         logic [31:0] sx, logic [31:0] sy, logic [31:0] sz);
    while (surface_queue.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    write_reg(REG_CENTER_X, {32'h0, cx});
    write_reg(REG_CENTER_Y, {32'h0, cy});
    write_reg(REG_CENTER_Z, {32'h0, cz});
    write_reg(REG_EXTENT_X, {33'h0, ex});
    write_reg(REG_EXTENT_Y, {33'h0, ey});
    write_reg(REG_EXTENT_Z, {33'h0, ez});
    write_reg(REG_SHELL_XY, {sy, sx});
    write_reg(REG_SHELL_Z, {32'h0, sz});
  endtask

  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz, bit ob);
    while (!no_idle && $urandom_range(99) < 35) @(negedge clk);
    in_data = '{point_x: px, point_y: py, point_z: pz, outer_box: ob};
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    surface_queue.push_back(project_point(in_data));
    requests_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  always @(negedge clk) out_ready <= no_idle || $urandom_range(99) >= 35;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (surface_queue.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        out_t want;
        want = surface_queue.pop_front();
        results_seen++;
        if (want !== out_data) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, out_data);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000 | $urandom_range(15);
      1: return 32'h7fff_fff0 | $urandom_range(15);
      2: return $urandom_range(8) << 16;
      3: return 32'($signed($urandom_range(400000)) - 200000);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed;
    set_box(0, 0, 0, 31'h10000, 31'h10000, 31'h10000, 0, 0, 0);
    send_point(0, 0, 0, 0);
    send_point(0, 0, 0, 1);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
    send_point(32'h10000, 32'h10000, 0, 0);
    send_point(32'h10000, 32'h10000, 32'h10000, 1);
    send_point(3, 1, 0, 0);
    send_point(32'hffff_ffff, 0, 0, 0);
    set_box(32'h7fff_ffff, 32'h8000_0000, 0, 31'h7fff_ffff, 31'h7fff_ffff,
            31'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_point(32'h8000_0000, 32'h7fff_ffff, 1, 0);
    send_point(32'h8000_0000, 32'h7fff_ffff, 1, 1);
    send_point(32'h7fff_ffff, 32'h8000_0000, 0, 1);
    send_point(0, 0, 32'h7fff_ffff, 0);
    set_box(0, 0, 0, 0, 31'h100, 31'h100, 0, 0, 0);
    send_point(5, 6, 7, 0);
    send_point(5, 6, 7, 1);
    set_box(0, 0, 0, 31'h100, 31'h100, 0, 0, 0, 32'h40);
    send_point(5, 6, 7, 0);
    send_point(5, 6, 7, 1);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1);
  endtask

  task automatic test_random(int n);
    set_box($urandom, $urandom, $urandom, $urandom_range(5) == 0 ? 0 : $urandom,
            $urandom_range(1 << 20), $urandom, {$urandom}, $urandom_range(1 << 18),
            $urandom);
    for (int i = 0; i < n; i++)
      send_point(pick_coord(), pick_coord(), pick_coord(), $urandom_range(1));
  endtask

  initial begin
    ctr = '{0, 0, 0};
    ext_inner = '{34'h10000, 34'h10000, 34'h10000};
    shell_w = '{0, 0, 0};
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    test_directed();
    for (int k = 0; k < 6; k++) test_random(200);
    no_idle = 1'b1;
    test_random(200);
    no_idle = 1'b0;
    test_random(250);
    while (surface_queue.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("covered %0d points, %0d results across directed and random box setups",
             requests_sent, results_seen);
    if (errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

  initial begin
    #5ms;
    $display("testbench: errors");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/bsp_pkg.sv
hw/rtl/bsp_prep.sv
hw/rtl/bsp_pick.sv
hw/rtl/bsp_div_lane.sv
hw/rtl/box_surface_projection.sv
test/testbench.sv
